>>> hdl/tssd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and glyph functions for the thermometer display.
// No dependencies; every other file in hdl/ uses this package.
package tssd_pkg;

  localparam int TempW = 14;

  typedef struct packed {
    logic [7:0] adc_sample;
    logic       celsius_mode;
  } sample_t;

  typedef struct packed {
    logic [3:0] digit_select;
    logic [7:0] segment_pattern;
    logic       last_digit;
  } scan_t;

  // Index 0 is the unit letter, 1 tenths, 2 units with point, 3 tens.
  typedef struct packed {
    logic [3:0][7:0] pattern;
  } glyph_set_t;

  // Numerator scale: C is s*1000/51, F is s*1800/51 (same as s*600/17).
  localparam logic [10:0] ScaleC = 11'd1000;
  localparam logic [10:0] ScaleF = 11'd1800;
  localparam logic [5:0]  Div51  = 6'd51;

  // floor(2^24 / 51); the estimate is the quotient or one below it.
  localparam logic [18:0] Recip51  = 19'd328965;
  localparam int          RecipSh  = 24;

  localparam logic [TempW-1:0] FOffset  = 14'd320;
  localparam logic [TempW-1:0] TempMaxC = 14'd5000;
  localparam logic [TempW-1:0] TempMaxF = 14'd9320;

  // Exact reciprocals for t below 10000.
  localparam logic [15:0] Recip10   = 16'd52429;
  localparam int          Recip10Sh = 19;
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam int          Recip100Sh = 19;
  localparam logic [14:0] Recip1000 = 15'd16778;
  localparam int          Recip1000Sh = 24;

  localparam logic [7:0] LetterC    = 8'hC6;
  localparam logic [7:0] LetterF    = 8'h8E;
  localparam logic [7:0] DpOnMask   = 8'h7F;
  localparam logic [7:0] BlankGlyph = 8'hFF;

  localparam logic [1:0] DigitLast = 2'd3;

  localparam logic [3:0] ScanDigit0 = 4'h0E;
  localparam logic [3:0] ScanDigit1 = 4'h0D;
  localparam logic [3:0] ScanDigit2 = 4'h0B;
  localparam logic [3:0] ScanDigit3 = 4'h07;

  function automatic logic [7:0] seg_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h98;
      default: g = BlankGlyph;
    endcase
    return g;
  endfunction

  function automatic logic [3:0] scan_line(input logic [1:0] k);
    logic [3:0] s;
    case (k)
      2'd0:    s = ScanDigit0;
      2'd1:    s = ScanDigit1;
      2'd2:    s = ScanDigit2;
      default: s = ScanDigit3;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/tssd_quot.sv
`timescale 1ns / 1ps
// Three-stage temperature pipeline: scale, reciprocal multiply, correct.
// Depends on tssd_pkg.
module tssd_quot (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tssd_pkg::sample_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tssd_pkg::TempW-1:0]  out_temp,
  output logic                        out_celsius
);

  logic        v1, v2, v3;
  logic        adv1, adv2, adv3;
  logic [18:0] n1, n2;
  logic        c1, c2, c3;
  logic [tssd_pkg::TempW-1:0] qe2, t3;

  logic [10:0] scale;
  logic [18:0] n1_next;
  logic [37:0] prod;
  logic [19:0] qd;
  logic [19:0] rem;
  logic [tssd_pkg::TempW-1:0] q;
  logic [tssd_pkg::TempW-1:0] t3_next;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign scale   = in_data.celsius_mode ? tssd_pkg::ScaleC : tssd_pkg::ScaleF;
  assign n1_next = 19'(in_data.adc_sample) * 19'(scale);

  assign prod = 38'(n1) * 38'(tssd_pkg::Recip51);

  // Bump the estimate when the remainder still holds a whole divisor.
  assign qd      = 20'(qe2) * 20'(tssd_pkg::Div51);
  assign rem     = 20'(n2) - qd;
  assign q       = qe2 + tssd_pkg::TempW'(rem >= 20'(tssd_pkg::Div51));
  assign t3_next = q + (c2 ? tssd_pkg::TempW'(0) : tssd_pkg::FOffset);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      n1 <= n1_next;
      c1 <= in_data.celsius_mode;
    end
    if (adv2) begin
      qe2 <= prod[tssd_pkg::RecipSh +: tssd_pkg::TempW];
      n2  <= n1;
      c2  <= c1;
    end
    if (adv3) begin
      t3 <= t3_next;
      c3 <= c2;
    end
  end

  assign out_valid   = v3;
  assign out_temp    = t3;
  assign out_celsius = c3;

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> t3 <= tssd_pkg::TempMaxF)
    else $error("temperature above full scale");

  a_celsius_range: assert property (@(posedge clk) disable iff (rst)
    v3 && c3 |-> t3 <= tssd_pkg::TempMaxC)
    else $error("Celsius temperature above full scale");

endmodule

>>> hdl/tssd_digits.sv
`timescale 1ns / 1ps
// Two-stage decimal split of the temperature and glyph lookup.
// Depends on tssd_pkg.
module tssd_digits (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tssd_pkg::TempW-1:0]  in_temp,
  input  logic                        in_celsius,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tssd_pkg::glyph_set_t        out_data
);

  logic v4, v5;
  logic adv4, adv5;

  logic [tssd_pkg::TempW-1:0] t4;
  logic       c4;
  logic [9:0] q10;
  logic [6:0] q100;
  logic [3:0] q1000;

  logic [29:0] p10;
  logic [26:0] p100;
  logic [28:0] p1000;

  logic [tssd_pkg::TempW-1:0] d0w;
  logic [9:0] d1w;
  logic [6:0] d2w;

  tssd_pkg::glyph_set_t set_next, set5;

  assign adv5     = !v5 || out_ready;
  assign adv4     = !v4 || adv5;
  assign in_ready = adv4;

  assign p10   = 30'(in_temp) * 30'(tssd_pkg::Recip10);
  assign p100  = 27'(in_temp) * 27'(tssd_pkg::Recip100);
  assign p1000 = 29'(in_temp) * 29'(tssd_pkg::Recip1000);

  // Subtract ten of the next quotient to leave each digit.
  assign d0w = t4 - tssd_pkg::TempW'(q10) * tssd_pkg::TempW'(10);
  assign d1w = q10 - 10'(q100) * 10'd10;
  assign d2w = q100 - 7'(q1000) * 7'd10;

  always_comb begin
    set_next.pattern[0] = c4 ? tssd_pkg::LetterC : tssd_pkg::LetterF;
    set_next.pattern[1] = tssd_pkg::seg_glyph(d0w[3:0]);
    set_next.pattern[2] = tssd_pkg::seg_glyph(d1w[3:0]) & tssd_pkg::DpOnMask;
    set_next.pattern[3] = tssd_pkg::seg_glyph(d2w[3:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv4) v4 <= in_valid;
      if (adv5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      t4    <= in_temp;
      c4    <= in_celsius;
      q10   <= p10[tssd_pkg::Recip10Sh +: 10];
      q100  <= p100[tssd_pkg::Recip100Sh +: 7];
      q1000 <= p1000[tssd_pkg::Recip1000Sh +: 4];
    end
    if (adv5) set5 <= set_next;
  end

  assign out_valid = v5;
  assign out_data  = set5;

  a_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    v5 |-> set5.pattern[1] != tssd_pkg::BlankGlyph &&
           set5.pattern[3] != tssd_pkg::BlankGlyph)
    else $error("digit split produced a non-decimal digit");

endmodule

>>> hdl/tssd_scan.sv
`timescale 1ns / 1ps
// Scan register: holds one glyph set and sends its four digits in order.
// Depends on tssd_pkg.
module tssd_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tssd_pkg::glyph_set_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tssd_pkg::scan_t       out_data
);

  logic                 sv;
  logic [1:0]           idx;
  tssd_pkg::glyph_set_t set;
  logic                 done;

  assign done     = sv && out_ready && (idx == tssd_pkg::DigitLast);
  assign in_ready = !sv || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv  <= 1'b0;
      idx <= 2'd0;
    end else if (in_ready) begin
      sv  <= in_valid;
      idx <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) set <= in_data;
  end

  assign out_valid                = sv;
  assign out_data.digit_select    = tssd_pkg::scan_line(idx);
  assign out_data.segment_pattern = set.pattern[idx];
  assign out_data.last_digit      = (idx == tssd_pkg::DigitLast);

  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    sv && out_ready && idx != tssd_pkg::DigitLast |=> sv && idx == $past(idx) + 2'd1)
    else $error("scan did not advance to the next digit");

  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    sv && !out_ready |=> sv && $stable(idx) && $stable(set))
    else $error("scan moved while stalled");

endmodule

>>> hdl/thermometer_seven_segment_display.sv
`timescale 1ns / 1ps
// Top level of the thermometer display: sample in, four digit scans out.
// Depends on tssd_pkg, tssd_quot, tssd_digits and tssd_scan.
//
// Each request on the sample channel carries one 8-bit converter reading and a
// unit switch; the block answers with four requests on the scan channel, digit
// 0 to 3 in order: the unit letter, tenths, units with the decimal point, and
// tens. The thousands digit is not shown. Temperature is computed exactly in
// tenths of a degree: floor(s*1000/51) for Celsius, floor(s*600/17)+320 for
// Fahrenheit. Five pipeline registers (scale, reciprocal multiply, correct,
// decimal split, glyph lookup) feed a scan register, which offers the digits
// of a sample once it has passed all five. The scan channel moves one digit
// per cycle while scan_ready is held high, so the sustained rate is one sample
// per four digits scanned; the pipeline keeps taking samples while a scan is
// in progress until its five stages are full, and a stall on the scan side
// holds every stage without loss or repeat. There is no configuration and no
// state kept between samples.
module thermometer_seven_segment_display (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  tssd_pkg::sample_t  sample,
  output logic               scan_valid,
  input  logic               scan_ready,
  output tssd_pkg::scan_t    scan
);

  logic                       temp_valid;
  logic                       temp_ready;
  logic [tssd_pkg::TempW-1:0] temp;
  logic                       temp_celsius;

  logic                       glyph_valid;
  logic                       glyph_ready;
  tssd_pkg::glyph_set_t       glyphs;

  // Convert the reading to tenths of a degree.
  tssd_quot u_quot (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample_valid),
    .in_ready    (sample_ready),
    .in_data     (sample),
    .out_valid   (temp_valid),
    .out_ready   (temp_ready),
    .out_temp    (temp),
    .out_celsius (temp_celsius)
  );

  // Split into decimal digits and look up segment patterns.
  tssd_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (temp_valid),
    .in_ready   (temp_ready),
    .in_temp    (temp),
    .in_celsius (temp_celsius),
    .out_valid  (glyph_valid),
    .out_ready  (glyph_ready),
    .out_data   (glyphs)
  );

  // Hold the glyph set and advance one digit per accepted scan request.
  tssd_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (glyph_valid),
    .in_ready  (glyph_ready),
    .in_data   (glyphs),
    .out_valid (scan_valid),
    .out_ready (scan_ready),
    .out_data  (scan)
  );

endmodule

>>> tb/tb_thermometer_seven_segment_display.sv
`timescale 1ns / 1ps
// Testbench for thermometer_seven_segment_display: directed and random samples,
// checked digit by digit against an in-bench predictor of the four-digit scan.
// Depends on tssd_pkg and the RTL top level; reads no files.

import tssd_pkg::*;

// Keeps the digit scans still owed by the block and checks each one that
// leaves it.
class digit_scan_book;
  scan_t       owed_digits[$];
  int          miscount;
  logic [7:0]  numeral_glyph[10];

  function new();
    numeral_glyph = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                      8'h92, 8'h82, 8'hF8, 8'h80, 8'h98};
    miscount = 0;
  endfunction

  function int pending();
    return owed_digits.size();
  endfunction

  // Work out the temperature in tenths, then queue the four digits of the scan.
  function void note_sample(sample_t req);
    int    s;
    int    tenths;
    scan_t d;
    s = int'(req.adc_sample);
    if (req.celsius_mode)
      tenths = (s * 1000) / 51;
    else
      tenths = (s * 600) / 17 + 320;

    d.digit_select    = ScanDigit0;
    d.segment_pattern = req.celsius_mode ? LetterC : LetterF;
    d.last_digit      = 1'b0;
    owed_digits.push_back(d);

    d.digit_select    = ScanDigit1;
    d.segment_pattern = numeral_glyph[tenths % 10];
    owed_digits.push_back(d);

    // units carry the lit decimal point
    d.digit_select    = ScanDigit2;
    d.segment_pattern = numeral_glyph[(tenths / 10) % 10] & DpOnMask;
    owed_digits.push_back(d);

    // tens; anything above is dropped from the display
    d.digit_select    = ScanDigit3;
    d.segment_pattern = numeral_glyph[(tenths / 100) % 10];
    d.last_digit      = 1'b1;
    owed_digits.push_back(d);
  endfunction

  function void check_scan(scan_t got);
    scan_t want;
    if (owed_digits.size() == 0) begin
      $error("scan request with no digit owed: select %h pattern %h last %b",
             got.digit_select, got.segment_pattern, got.last_digit);
      miscount++;
      return;
    end
    want = owed_digits.pop_front();
    if (got.digit_select !== want.digit_select) begin
      $error("digit_select: expected %h, got %h", want.digit_select, got.digit_select);
      miscount++;
    end
    if (got.segment_pattern !== want.segment_pattern) begin
      $error("segment_pattern: expected %h, got %h",
             want.segment_pattern, got.segment_pattern);
      miscount++;
    end
    if (got.last_digit !== want.last_digit) begin
      $error("last_digit: expected %b, got %b", want.last_digit, got.last_digit);
      miscount++;
    end
  endfunction
endclass

module tb_thermometer_seven_segment_display;

  localparam int RandomSamples = 300;
  // Cycles without any request moving before the run is called hung. The worst
  // correct stretch is a withheld span on the scan side followed by the long
  // hold, plus pipeline depth.
  localparam int HangLimit = 3000;
  localparam int LongHold  = 100;

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_ready;
  sample_t sample;
  logic    scan_valid;
  logic    scan_ready;
  scan_t   scan;

  digit_scan_book book = new();

  // Scan-side hold handshake: the stimulus asks, the scan driver serves.
  int hold_asks;
  int hold_served;
  int quiet_cycles;

  thermometer_seven_segment_display dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .scan_valid  (scan_valid),
    .scan_ready  (scan_ready),
    .scan        (scan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Note accepted samples before checking digits; a sample's digits come out
  // several cycles later, so the order only matters for bookkeeping.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready)
        book.note_sample(sample);
      if (scan_valid && scan_ready)
        book.check_scan(scan);
    end
  end

  // Watchdog: count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (scan_valid && scan_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("thermometer_seven_segment_display: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Scan side: stretches of steady, patchy and withheld ready, plus the long
  // hold when the stimulus asks for one. At most one update per falling edge.
  initial begin : scan_driver
    int mode;
    int span;
    scan_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_served != hold_asks) begin
        scan_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_served++;
      end else begin
        mode = $urandom_range(0, 9);
        span = $urandom_range(10, 50);
        repeat (span) begin
          case (mode)
            0, 1, 2, 3: scan_ready <= 1'b1;
            4, 5, 6:    scan_ready <= ($urandom_range(0, 9) < 7);
            7, 8:       scan_ready <= ($urandom_range(0, 9) < 3);
            default:    scan_ready <= 1'b0;
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // Offer one sample and hold it until the block takes it.
  task automatic offer_sample(input logic [7:0] adc, input logic celsius);
    @(negedge clk);
    sample_valid        <= 1'b1;
    sample.adc_sample   <= adc;
    sample.celsius_mode <= celsius;
    do @(posedge clk); while (!sample_ready);
  endtask

  // Drop valid for a gap set by n; zero keeps the next sample back to back.
  task automatic rest_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the sender until every owed digit has come out.
  task automatic drain_scans();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] adc_pick[18];
    logic       unit_pick[18];
    int         burst;

    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    hold_asks    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners: range ends in both units, thousands digit just
    // reached and just missed, the nine glyph in several places, and
    // alternating bit patterns.
    adc_pick  = '{8'd0,   8'd0,   8'd255, 8'd255, 8'd1,   8'd1,
                  8'd51,  8'd52,  8'd19,  8'd20,  8'd5,   8'd46,
                  8'd128, 8'd170, 8'd170, 8'h55,  8'hAA,  8'hAA};
    unit_pick = '{1'b1,   1'b0,   1'b1,   1'b0,   1'b1,   1'b0,
                  1'b1,   1'b1,   1'b0,   1'b0,   1'b1,   1'b1,
                  1'b0,   1'b1,   1'b0,   1'b1,   1'b0,   1'b1};
    for (int i = 0; i < 18; i++) begin
      offer_sample(adc_pick[i], unit_pick[i]);
      rest_sender(pick_gap());
    end

    // Pause the sender until the directed scans are all out.
    drain_scans();

    for (int i = 0; i < RandomSamples; i++) begin
      // Ask for a long scan-side hold and push samples back to back so the
      // pipeline fills and the sample side has to wait.
      if (i == 100 || i == 250) begin
        hold_asks++;
        for (burst = 0; burst < 20; burst++)
          offer_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      // Pause the sender again mid-run.
      if (i == 180)
        drain_scans();
      offer_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      rest_sender(pick_gap());
    end

    drain_scans();
    // Let the tail settle to catch any stray digit.
    repeat (20) @(posedge clk);
    if (book.miscount == 0)
      $display("thermometer_seven_segment_display: match");
    else
      $display("thermometer_seven_segment_display: mismatch");
    $finish;
  end

endmodule
